// File: src/osl_pkg.sv
// osl_pkg: shared types and codes for the ordered shift list.
// No dependencies; imported by every other file of the block except osl_if.sv.
package osl_pkg;

  typedef enum logic [2:0] {
    K_INS_FRONT = 3'd0,
    K_INS_REAR  = 3'd1,
    K_INS_POS   = 3'd2,
    K_INS_SORT  = 3'd3,
    K_DEL_FRONT = 3'd4,
    K_DEL_REAR  = 3'd5,
    K_DEL_POS   = 3'd6,
    K_READ      = 3'd7
  } osl_kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } osl_status_e;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2
  } osl_op_e;

  // Broadcast command from the controller to every cell.
  typedef struct packed {
    osl_op_e    op;
    logic       sorted;
    logic [7:0] value;
  } osl_cmd_t;

endpackage

// File: src/osl_if.sv
// osl_req_if / osl_rsp_if: valid/ready channels of the ordered shift list.
// Depends on nothing; used by ordered_shift_list_core.
interface osl_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic signed [7:0] value;
  logic [3:0]        position;

  modport source (output valid, kind, value, position, input ready);
  modport sink   (input valid, kind, value, position, output ready);
endinterface

interface osl_rsp_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [4:0]        entry_count;
  logic signed [7:0] read_value;

  modport source (output valid, status, entry_count, read_value, input ready);
  modport sink   (input valid, status, entry_count, read_value, output ready);
endinterface

// File: src/ordered_shift_list_core.sv
// ordered_shift_list_core: fixed-capacity list of signed bytes in a row of cells.
// The response is registered and valid in the cycle after the request transfer; one request per cycle.
// All cells shift in the same cycle; the sorted-insert spot is found by an OR chain
// across the row. Throughput drops only while the response register is stalled.
// Reset (async, active low) empties the list and drops the response; cell data is not reset.
module ordered_shift_list_core
  import osl_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  osl_req_if.sink   req_i,
  osl_rsp_if.source rsp_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CMP_W = (CNT_W > 4) ? CNT_W : 4;
  localparam logic [CNT_W-1:0] Full = CNT_W'(DEPTH);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             fire;
  osl_kind_e        kind;
  osl_cmd_t         cmd;
  osl_status_e      st;
  logic [CNT_W-1:0] at, pos_c;
  logic [CMP_W-1:0] pos_x, cnt_x;
  logic [7:0]       rd;
  logic [7:0]       cell_q [DEPTH];
  logic             sfx [DEPTH+1];

  logic             rsp_valid_q;
  osl_status_e      rsp_status_q;
  logic [4:0]       rsp_count_q;
  logic [7:0]       rsp_rd_q;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;
  assign kind        = osl_kind_e'(req_i.kind);

  assign pos_x = CMP_W'(req_i.position);
  assign cnt_x = CMP_W'(cnt_q);
  assign pos_c = (pos_x > cnt_x) ? cnt_q : CNT_W'(pos_x);

  always_comb begin
    cmd.op     = OP_HOLD;
    cmd.sorted = 1'b0;
    cmd.value  = req_i.value;
    at         = '0;
    st         = ST_OK;
    cnt_d      = cnt_q;
    rd         = '0;
    unique case (kind) inside
      K_INS_FRONT, K_INS_REAR, K_INS_POS, K_INS_SORT: begin
        if (cnt_q == Full) begin
          st = ST_FULL;
        end else begin
          cmd.op = OP_INS;
          cnt_d  = cnt_q + CNT_W'(1);
          case (kind)
            K_INS_REAR: at = cnt_q;
            K_INS_POS:  at = pos_c;
            K_INS_SORT: cmd.sorted = 1'b1;
            default:    at = '0;
          endcase
        end
      end
      K_DEL_FRONT, K_DEL_REAR: begin
        if (cnt_q == '0) begin
          st = ST_EMPTY;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
          if (kind == K_DEL_FRONT) begin
            cmd.op = OP_DEL;
          end
        end
      end
      K_DEL_POS, K_READ: begin
        if (cnt_q == '0) begin
          st = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          st = ST_RANGE;
        end else if (kind == K_DEL_POS) begin
          cmd.op = OP_DEL;
          at     = pos_c;
          cnt_d  = cnt_q - CNT_W'(1);
        end else begin
          rd = cell_q[pos_c[IDX_W-1:0]];
        end
      end
      default: st = ST_OK;
    endcase
    if (!fire) begin
      cmd.op = OP_HOLD;
    end
  end

  assign sfx[DEPTH] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [7:0] left_d, right_d;
    logic       s_left;
    if (i == 0) begin : g_first
      assign left_d = cell_q[i];
      assign s_left = 1'b1;
    end else begin : g_mid
      assign left_d = cell_q[i-1];
      assign s_left = sfx[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_q[i];
    end else begin : g_inner
      assign right_d = cell_q[i+1];
    end
    osl_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .at_i      (at),
      .cnt_i     (cnt_q),
      .left_i    (left_d),
      .right_i   (right_d),
      .s_left_i  (s_left),
      .s_right_i (sfx[i+1]),
      .s_self_o  (sfx[i]),
      .q_o       (cell_q[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        cnt_q <= cnt_d;
      end
      if (fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_status_q <= st;
      rsp_count_q  <= 5'(cnt_d);
      rsp_rd_q     <= rd;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.entry_count = rsp_count_q;
  assign rsp_o.read_value  = rsp_rd_q;

endmodule

// File: src/osl_cell.sv
// osl_cell: one storage cell of the list; shifts with its neighbors.
// Depends on osl_pkg.
module osl_cell
  import osl_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic             clk_i,
  input  osl_cmd_t         cmd_i,
  input  logic [CNT_W-1:0] at_i,
  input  logic [CNT_W-1:0] cnt_i,
  input  logic [7:0]       left_i,
  input  logic [7:0]       right_i,
  input  logic             s_left_i,
  input  logic             s_right_i,
  output logic             s_self_o,
  output logic [7:0]       q_o
);

  localparam logic [CNT_W-1:0] IdxC = CNT_W'(IDX);

  logic [7:0] q_q, q_d;
  logic       le, gt, ge;

  // le: held entry not greater than the new value; suffix OR runs leftward
  assign le       = (IdxC < cnt_i) && ($signed(q_q) <= $signed(cmd_i.value));
  assign s_self_o = le | s_right_i;

  always_comb begin
    if (cmd_i.sorted) begin
      gt = !s_left_i;
      ge = !s_self_o;
    end else begin
      gt = IdxC > at_i;
      ge = IdxC >= at_i;
    end
    q_d = q_q;
    case (cmd_i.op)
      OP_INS: begin
        if (gt) begin
          q_d = left_i;
        end else if (ge) begin
          q_d = cmd_i.value;
        end
      end
      OP_DEL: begin
        if (ge) begin
          q_d = right_i;
        end
      end
      default: q_d = q_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign q_o = q_q;

endmodule

// File: src/osl_checker.sv
// osl_checker: port-level assertions for ordered_shift_list_core, plus its bind.
// Depends on osl_pkg and ordered_shift_list_core.
module osl_checker
  import osl_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [1:0] rsp_status_i,
  input logic [4:0] rsp_count_i,
  input logic [7:0] rsp_read_i
);

  // response holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_count_i) && $stable(rsp_read_i))
    else $error("stalled response changed");

  // every request transfer produces a response next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> rsp_valid_i)
    else $error("missing response");

  // an empty output register never blocks requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_i |-> req_ready_i)
    else $error("request blocked with free output");

  // empty refusal reports a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ST_EMPTY) |-> rsp_count_i == 5'd0)
    else $error("empty status with nonzero count");

  // only an ok response carries read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_read_i != 8'd0) |-> rsp_status_i == ST_OK)
    else $error("read data on refused request");

endmodule

bind ordered_shift_list_core osl_checker u_osl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_count_i  (rsp_o.entry_count),
  .rsp_read_i   (rsp_o.read_value)
);

// File: tb/sv/osl_list_checker.sv
// osl_list_checker: watches the request and response channels of the ordered shift list,
// predicts each response from its own copy of the list and compares field by field.
// Depends on osl_pkg and the osl_req_if / osl_rsp_if interfaces.
module osl_list_checker
  import osl_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  osl_req_if          req_i,
  osl_rsp_if          rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    osl_status_e       status;
    logic [4:0]        entry_count;
    logic signed [7:0] read_value;
  } list_rsp_t;

  logic signed [7:0] list_mem [DEPTH];
  int unsigned       list_len;
  list_rsp_t         expected_rsps [$];
  int unsigned       mismatches  = 0;
  int unsigned       outstanding = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  // Applies one request to the list copy and returns the response it should give.
  function automatic list_rsp_t apply_list_request(input osl_kind_e kind,
                                                   input logic signed [7:0] value,
                                                   input logic [3:0] position);
    list_rsp_t   rsp;
    int unsigned at;
    rsp.status     = ST_OK;
    rsp.read_value = '0;
    case (kind)
      K_INS_FRONT, K_INS_REAR, K_INS_POS, K_INS_SORT: begin
        if (list_len >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          case (kind)
            K_INS_FRONT: at = 0;
            K_INS_REAR:  at = list_len;
            K_INS_POS:   at = (position > list_len) ? list_len : position;
            default: begin
              at = list_len;
              while (at > 0 && value < list_mem[at-1]) at--;
            end
          endcase
          for (int unsigned i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
          list_mem[at] = value;
          list_len++;
        end
      end
      default: begin
        if (list_len == 0) begin
          rsp.status = ST_EMPTY;
        end else if (kind == K_DEL_FRONT) begin
          for (int unsigned i = 0; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end else if (kind == K_DEL_REAR) begin
          list_len--;
        end else if (position >= list_len) begin
          rsp.status = ST_RANGE;
        end else if (kind == K_DEL_POS) begin
          for (int unsigned i = position; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end else begin
          rsp.read_value = list_mem[position];
        end
      end
    endcase
    rsp.entry_count = list_len[4:0];
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    list_rsp_t got;
    list_rsp_t want;
    if (!rst_ni) begin
      list_len = 0;
      expected_rsps.delete();
      outstanding = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        got.status      = osl_status_e'(rsp_i.status);
        got.entry_count = rsp_i.entry_count;
        got.read_value  = rsp_i.read_value;
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected response: status %0d count %0d value %0d",
                     $realtime, got.status, got.entry_count, got.read_value);
        end else begin
          want = expected_rsps.pop_front();
          if (got.status !== want.status || got.entry_count !== want.entry_count ||
              got.read_value !== want.read_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected status %0d count %0d value %0d, got status %0d count %0d value %0d",
                       $realtime, want.status, want.entry_count, want.read_value,
                       got.status, got.entry_count, got.read_value);
          end
        end
      end
      if (req_i.valid && req_i.ready)
        expected_rsps.push_back(apply_list_request(osl_kind_e'(req_i.kind), req_i.value,
                                                   req_i.position));
      outstanding = expected_rsps.size();
    end
  end

endmodule

// File: tb/sv/testbench.sv
// testbench: clock, reset and request/response traffic for ordered_shift_list_core.
// Depends on osl_pkg, the osl channel interfaces and osl_list_checker.
module testbench
  import osl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int          cur_phase = -1;
  int unsigned sender_idle [4] = '{0, 52, 0, 20};
  int unsigned rcvr_stall [4]  = '{0, 0, 52, 20};

  osl_req_if req_ch ();
  osl_rsp_if rsp_ch ();

  ordered_shift_list_core #(.DEPTH(16)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  osl_list_checker #(.DEPTH(16)) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: random stalls, and one long hold-off in the fifth phase.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (cur_phase == 4 && !hold_done) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        rsp_ch.ready = 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_request(input osl_kind_e kind, input logic signed [7:0] value,
                              input logic [3:0] position);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid    = 1'b0;
      req_ch.kind     = 3'($urandom_range(7));
      req_ch.value    = 8'($urandom_range(255));
      req_ch.position = 4'($urandom_range(15));
      @(negedge clk_i);
    end
    req_ch.valid    = 1'b1;
    req_ch.kind     = kind;
    req_ch.value    = value;
    req_ch.position = position;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Bursts lean toward filling or draining so the list swings between empty and full.
  task automatic send_random_burst(input int unsigned n);
    int unsigned       ins_pct;
    int unsigned       r;
    osl_kind_e         kind;
    logic signed [7:0] value;
    logic [3:0]        position;
    ins_pct = 50;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: ins_pct = 70;
          1: ins_pct = 20;
          default: ins_pct = 45;
        endcase
      end
      r = $urandom_range(99);
      if (r < ins_pct) kind = osl_kind_e'($urandom_range(3));
      else if (r < 85) kind = osl_kind_e'($urandom_range(6, 4));
      else kind = K_READ;
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: value = -8'sd128;
          1: value = 8'sd127;
          2: value = 8'sd0;
          default: value = -8'sd1;
        endcase
      end else begin
        value = 8'($urandom_range(255));
      end
      position = $urandom_range(1) ? 4'($urandom_range(15)) : 4'($urandom_range(7));
      send_request(kind, value, position);
    end
  endtask

  initial begin
    req_ch.valid    = 1'b0;
    req_ch.kind     = '0;
    req_ch.value    = '0;
    req_ch.position = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty list refusals
    send_request(K_DEL_FRONT, 8'sd0, 4'd0);
    send_request(K_DEL_REAR, 8'sd0, 4'd0);
    send_request(K_DEL_POS, 8'sd0, 4'd0);
    send_request(K_READ, 8'sd0, 4'd0);
    // sorted placement, equal values, position clamp, range and full refusals
    send_request(K_INS_SORT, 8'sd0, 4'd0);
    send_request(K_INS_SORT, -8'sd128, 4'd0);
    send_request(K_INS_SORT, 8'sd127, 4'd0);
    send_request(K_INS_SORT, 8'sd0, 4'd0);
    send_request(K_INS_POS, 8'sd5, 4'd15);
    send_request(K_INS_POS, -8'sd7, 4'd1);
    send_request(K_INS_FRONT, 8'sd127, 4'd0);
    send_request(K_INS_REAR, -8'sd128, 4'd0);
    send_request(K_READ, 8'sd0, 4'd0);
    send_request(K_READ, 8'sd0, 4'd15);
    send_request(K_DEL_POS, 8'sd0, 4'd15);
    send_request(K_DEL_POS, 8'sd0, 4'd3);
    send_request(K_DEL_FRONT, 8'sd0, 4'd0);
    repeat (10) send_request(K_INS_REAR, 8'($urandom_range(255)), 4'd0);
    send_request(K_INS_FRONT, 8'sd1, 4'd0);
    send_request(K_INS_POS, 8'sd1, 4'd0);
    send_request(K_DEL_REAR, 8'sd0, 4'd0);

    for (int p = 0; p < 8; p++) begin
      idle_pct  = sender_idle[p % 4];
      stall_pct = rcvr_stall[p % 4];
      cur_phase = p;
      send_random_burst(228);
    end

    @(negedge clk_i);
    req_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
